// ===== hw/rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Shared types, round constants and initial hash values.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

   localparam logic [7:0] PadByte = 8'h80;

   localparam logic [1:0] ADDR_MODE = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_ZERO,
      SRC_LEN_HI,
      SRC_LEN_LO
   } src_type;

   typedef struct packed {
      logic      push;
      src_type   src;
      logic      pad_word;
      logic      load_vars;
      logic      round;
      logic      update;
      logic      reload;
      logic      add_count;
      logic      clear_count;
   } cmd_type;

   typedef struct packed {
      logic       block_full;
      logic [3:0] fill;
      logic       round_done;
   } status_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k [64];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[i];
   endfunction

   function automatic logic [31:0] init_hash(input logic sha224, input logic [2:0] i);
      logic [31:0] h256 [8];
      logic [31:0] h224 [8];
      h256 = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      h224 = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
               32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
      return sha224 ? h224[i] : h256[i];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
      return (x >> r) | (x << (32 - r));
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sha256_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Message schedule window, round unit, hash words and byte counter.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sha256_pkg::cmd_type   cmd,
   input  wire logic [31:0]           in_word,
   input  wire logic [2:0]            in_bytes,
   input  wire logic                  in_last,
   input  wire logic                  mode,
   input  wire logic                  mode_write,
   input  wire logic [2:0]            out_sel,
   output sha256_pkg::status_type     status,
   output logic [31:0]                out_word
);

   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [3:0]  fill_ff, fill_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [63:0] count_ff, count_in;
   logic [31:0] push_data;
   logic [2:0]  nb;
   logic [31:0] mask;
   logic [31:0] w_new, s0, s1, t1, t2, ch, maj, wt;
   logic [63:0] bits;

   assign bits = {count_ff[60:0], 3'b000};

   always_comb begin
      nb = (in_bytes > 3'd4) ? 3'd4 : in_bytes;
      case (nb)
         3'd0: mask = 32'h0;
         3'd1: mask = 32'hff000000;
         3'd2: mask = 32'hffff0000;
         3'd3: mask = 32'hffffff00;
         default: mask = 32'hffffffff;
      endcase
      case (cmd.src)
         sha256_pkg::SRC_INPUT: begin
            if (cmd.pad_word)
               push_data = {sha256_pkg::PadByte, 24'h0};
            else if (in_last && nb != 3'd4)
               push_data = (in_word & mask) |
                           ({sha256_pkg::PadByte, 24'h0} >> {nb, 3'b000});
            else
               push_data = in_word;
         end
         sha256_pkg::SRC_LEN_HI: push_data = bits[63:32];
         sha256_pkg::SRC_LEN_LO: push_data = bits[31:0];
         default: push_data = 32'h0;
      endcase
   end

   always_comb begin
      s0 = sha256_pkg::rotr(w_ff[1], 7) ^ sha256_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha256_pkg::rotr(w_ff[14], 17) ^ sha256_pkg::rotr(w_ff[14], 19)
           ^ (w_ff[14] >> 10);
      w_new = s1 + w_ff[9] + s0 + w_ff[0];
      wt = w_ff[0];
      ch = v_ff[6] ^ (v_ff[4] & (v_ff[5] ^ v_ff[6]));
      maj = (v_ff[0] & v_ff[1]) | (v_ff[2] & (v_ff[0] | v_ff[1]));
      t1 = v_ff[7] + (sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
           ^ sha256_pkg::rotr(v_ff[4], 25)) + ch + sha256_pkg::round_k(rnd_ff) + wt;
      t2 = (sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
           ^ sha256_pkg::rotr(v_ff[0], 22)) + maj;
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.push)
         fill_in = fill_ff + 4'd1;
      rnd_in = rnd_ff;
      if (cmd.load_vars)
         rnd_in = 6'd0;
      else if (cmd.round)
         rnd_in = rnd_ff + 6'd1;
      count_in = count_ff;
      if (cmd.clear_count)
         count_in = 64'd0;
      else if (cmd.add_count)
         count_in = count_ff + (in_last ? {61'd0, nb} : 64'd4);
      for (int i = 0; i < 8; i++) begin
         hash_in[i] = hash_ff[i];
         if (cmd.update)
            hash_in[i] = hash_ff[i] + v_ff[i];
         else if (cmd.reload || (mode_write && count_ff == 64'd0 && fill_ff == 4'd0))
            hash_in[i] = sha256_pkg::init_hash(mode, 3'(i));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= 4'd0;
         rnd_ff   <= 6'd0;
         count_ff <= 64'd0;
         for (int i = 0; i < 8; i++)
            hash_ff[i] <= sha256_pkg::init_hash(1'b0, 3'(i));
      end else begin
         fill_ff  <= fill_in;
         rnd_ff   <= rnd_in;
         count_ff <= count_in;
         hash_ff  <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push)
         w_ff[fill_ff] <= push_data;
      else if (cmd.round) begin
         for (int i = 0; i < 15; i++)
            w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= w_new;
      end
      if (cmd.load_vars)
         v_ff <= hash_ff;
      else if (cmd.round) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   assign out_word = hash_ff[out_sel];
   assign status.block_full = (fill_ff == 4'd15) && cmd.push;
   assign status.fill = fill_ff;
   assign status.round_done = (rnd_ff == 6'd63);

endmodule
`default_nettype wire

// ===== hw/rtl/sha256_control.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences buffering, padding, compression and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_control (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire logic                   in_last,
   input  wire logic [2:0]             in_bytes,
   output logic                        in_ready,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic                        out_last,
   output logic [2:0]                  out_sel,
   input  wire sha256_pkg::status_type status,
   output sha256_pkg::cmd_type         cmd
);

   sha256_pkg::state_type state_ff, state_in;
   // pad stage: 0 none, 1 pad word pending, 2 zeros, 3 length hi, 4 length lo
   logic [2:0] pad_ff, pad_in;
   logic [2:0] sel_ff, sel_in;
   logic       fin_ff, fin_in;

   localparam logic [2:0] PadNone = 3'd0;
   localparam logic [2:0] PadMark = 3'd1;
   localparam logic [2:0] PadZero = 3'd2;
   localparam logic [2:0] PadHi   = 3'd3;
   localparam logic [2:0] PadLo   = 3'd4;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         pad_ff   <= PadNone;
         sel_ff   <= 3'd0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pad_ff   <= pad_in;
         sel_ff   <= sel_in;
         fin_ff   <= fin_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pad_in   = pad_ff;
      sel_in   = sel_ff;
      fin_in   = fin_ff;
      cmd      = '0;
      cmd.src  = sha256_pkg::SRC_ZERO;
      in_ready = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         sha256_pkg::ST_IDLE: begin
            case (pad_ff)
               PadNone: begin
                  in_ready = 1'b1;
                  if (in_valid) begin
                     cmd.push = 1'b1;
                     cmd.src = sha256_pkg::SRC_INPUT;
                     cmd.add_count = 1'b1;
                     if (in_last)
                        pad_in = (in_bytes >= 3'd4) ? PadMark : PadZero;
                  end
               end
               PadMark: begin
                  cmd.push = 1'b1;
                  cmd.src = sha256_pkg::SRC_INPUT;
                  cmd.pad_word = 1'b1;
                  pad_in = PadZero;
               end
               PadZero: begin
                  if (status.fill == 4'd14)
                     pad_in = PadHi;
                  else
                     cmd.push = 1'b1;
               end
               PadHi: begin
                  cmd.push = 1'b1;
                  cmd.src = sha256_pkg::SRC_LEN_HI;
                  pad_in = PadLo;
               end
               default: begin
                  cmd.push = 1'b1;
                  cmd.src = sha256_pkg::SRC_LEN_LO;
                  pad_in = PadNone;
                  fin_in = 1'b1;
               end
            endcase
            if (status.block_full)
               state_in = sha256_pkg::ST_LOAD;
         end
         sha256_pkg::ST_LOAD: begin
            cmd.load_vars = 1'b1;
            state_in = sha256_pkg::ST_ROUND;
         end
         sha256_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            if (status.round_done)
               state_in = sha256_pkg::ST_UPDATE;
         end
         sha256_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            sel_in = 3'd0;
            state_in = fin_ff ? sha256_pkg::ST_EMIT : sha256_pkg::ST_IDLE;
         end
         sha256_pkg::ST_EMIT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               sel_in = sel_ff + 3'd1;
               if (sel_ff == 3'd7) begin
                  cmd.reload = 1'b1;
                  cmd.clear_count = 1'b1;
                  fin_in = 1'b0;
                  state_in = sha256_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   assign out_sel  = sel_ff;
   assign out_last = (sel_ff == 3'd7);

endmodule
`default_nettype wire

// ===== hw/rtl/sha256_hash_engine_unit.sv =====
// After the last beat, padding and both length words are pushed, then one or two
// compressions run before the first digest beat.
// Throughput: one word per cycle while filling; no input is taken during compression.
// Output: 8 digest beats, one per cycle while the sink is ready.
// Reset: synchronous, active high; loads SHA-256 initial values, mode 0.
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Streaming message words in, eight digest words out, APB mode register.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_hash_engine_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // message_word[31:0], valid_bytes[34:32], zeros
   input  wire logic        req_tlast,   // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // digest_word[31:0]
   output logic             rsp_tlast,   // digest_last
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   sha256_pkg::cmd_type    cmd;
   sha256_pkg::status_type status;
   logic [2:0] out_sel;
   logic       mode_ff, mode_in, mode_write;

   assign csr_pready = 1'b1;
   assign mode_write = csr_psel && csr_penable && csr_pwrite
                       && csr_paddr == sha256_pkg::ADDR_MODE;
   assign mode_in = mode_write ? csr_pwdata[0] : mode_ff;
   assign csr_prdata = (csr_paddr == sha256_pkg::ADDR_MODE) ? {31'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset)
         mode_ff <= 1'b0;
      else
         mode_ff <= mode_in;
   end

   sha256_control u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_last(req_tlast), .in_bytes(req_tdata[34:32]),
      .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_last(rsp_tlast),
      .out_sel(out_sel), .status(status), .cmd(cmd)
   );

   sha256_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .in_word(req_tdata[31:0]), .in_bytes(req_tdata[34:32]), .in_last(req_tlast),
      .mode(mode_in), .mode_write(mode_write), .out_sel(out_sel),
      .status(status), .out_word(rsp_tdata)
   );

`ifndef SYNTHESIS
   a_no_in_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken during digest output");
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("output continues past last beat");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
`endif

endmodule
`default_nettype wire

// ===== verif/sha256_hash_engine_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the message and digest streams and the mode register writes,
// computes each digest on its own and compares every digest beat in order.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_hash_engine_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,   // message_word[31:0], valid_bytes[34:32], zeros
   input  wire logic        req_tlast,   // is_last
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // digest_word[31:0]
   input  wire logic        rsp_tlast,   // digest_last
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               error_count,
   output int               digest_pending
);

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } digest_beat_type;

   localparam logic [31:0] K_TAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] IV256 [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
      32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   localparam logic [31:0] IV224 [8] = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17,
      32'hf70e5939, 32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

   logic        sel224;
   logic [31:0] chain [8];
   logic [31:0] blk [16];
   logic [4:0]  fill;
   logic [63:0] nbytes;
   digest_beat_type digest_q [$];

   function automatic logic [31:0] ror(logic [31:0] x, int r);
      return (x >> r) | (x << (32 - r));
   endfunction

   task automatic load_iv();
      for (int i = 0; i < 8; i++) chain[i] = sel224 ? IV224[i] : IV256[i];
   endtask

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + K_TAB[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   task automatic push_word(logic [31:0] x);
      blk[fill[3:0]] = x;
      fill++;
      if (fill >= 16) begin
         compress_block();
         fill = 0;
      end
   endtask

   task automatic absorb_beat(logic [31:0] word, logic [2:0] vb, logic fin);
      logic [63:0] bits;
      logic [31:0] mask;
      digest_beat_type b;
      if (!fin) begin
         nbytes += 4;
         push_word(word);
         return;
      end
      if (vb > 4) vb = 4;
      nbytes += vb;
      if (vb == 4) begin
         push_word(word);
         push_word(32'h8000_0000);
      end else begin
         mask = (vb == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * vb));
         push_word((word & mask) | (32'h8000_0000 >> (8 * vb)));
      end
      if (fill > 14) while (fill != 0) push_word(32'h0);
      while (fill < 14) push_word(32'h0);
      bits = nbytes << 3;
      push_word(bits[63:32]);
      push_word(bits[31:0]);
      for (int i = 0; i < 8; i++) begin
         b.word = chain[i];
         b.last = (i == 7);
         digest_q.push_back(b);
      end
      load_iv();
      nbytes = 0;
      fill = 0;
   endtask

   always @(posedge clock) begin
      digest_beat_type exp_b;
      if (reset) begin
         sel224 = 1'b0;
         load_iv();
         fill = 0;
         nbytes = 0;
         digest_q.delete();
         error_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == sha256_pkg::ADDR_MODE)
         begin
            sel224 = csr_pwdata[0];
            if (nbytes == 0 && fill == 0) load_iv();
         end
         if (rsp_tvalid && rsp_tready) begin
            if (digest_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected digest beat %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               exp_b = digest_q.pop_front();
               if (exp_b.word !== rsp_tdata || exp_b.last !== rsp_tlast) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("digest mismatch: expected %h/%b actual %h/%b",
                              exp_b.word, exp_b.last, rsp_tdata, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb_beat(req_tdata[31:0], req_tdata[34:32], req_tlast);
      end
      digest_pending = digest_q.size();
   end
endmodule
`default_nettype wire

// ===== verif/tb_sha256_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-256 engine testbench
// Streams directed and random messages in both modes under varying idle and
// stall patterns; a separate checker predicts and compares every digest beat.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_sha256_hash_engine_unit;

   localparam int CYCLE_LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          error_count;
   int          digest_pending;
   int          send_idle_pct = 0;
   int          sink_stall_pct = 0;
   int          cycle_count = 0;

   always #1 clock = ~clock;

   sha256_hash_engine_unit dut (.*);
   sha256_hash_engine_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_sha256_hash_engine_unit NOT OK");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);

   task automatic send_beat(logic [31:0] word, logic [2:0] vb, logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, vb, word};
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_mode(logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= sha256_pkg::ADDR_MODE;
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (digest_pending != 0) @(posedge clock);
      repeat (150) @(negedge clock);
   endtask

   // Send a message of nwords full words and a last beat.
   task automatic send_message(int nwords, logic [2:0] vb, logic [31:0] fixed, bit use_fixed);
      for (int i = 0; i < nwords; i++)
         send_beat(use_fixed ? fixed : $urandom(),
                   ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4, 1'b0);
      send_beat(use_fixed ? fixed : $urandom(), vb, 1'b1);
   endtask

   initial begin
      int len;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_beat(32'h0, 3'd0, 1'b1);
      send_beat(32'h61626300, 3'd3, 1'b1);
      send_message(0, 3'd4, 32'hffff_ffff, 1'b1);
      send_message(13, 3'd1, 32'h0, 1'b1);
      send_message(13, 3'd4, 32'hffff_ffff, 1'b1);
      send_beat(32'h1234_5678, 3'd7, 1'b1);
      send_beat(32'hdead_beef, 3'd5, 1'b1);
      send_beat(32'h8765_4321, 3'd2, 1'b0);
      send_beat(32'hcafe_f00d, 3'd6, 1'b1);
      drain();
      write_mode(32'h1);
      send_beat(32'h0, 3'd0, 1'b1);
      send_beat(32'h61626300, 3'd3, 1'b1);
      drain();
      write_mode(32'hffff_fffe);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 51 : (ph == 3) ? 19 : 0;
         sink_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 19 : 0;
         write_mode($urandom());
         for (int m = 0; m < 5; m++) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6);
            send_message(len, 3'($urandom_range(7)), 32'h0, 1'b0);
            if (m == 2) drain();
         end
         drain();
      end
      send_idle_pct = 0;
      sink_stall_pct = 0;

      @(posedge clock);
      while (digest_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("tb_sha256_hash_engine_unit OK");
      else
         $display("tb_sha256_hash_engine_unit NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
